[hw/rtl/tswq_pkg.sv]
// Package for the touch sample window qualifier.
// Register indexes, register reset values and field widths.
// No dependencies.
package tswq_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegInitialLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegInitialHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWindowMargin = 3'd2;
  localparam logic [CfgIdxW-1:0] RegXOffset      = 3'd3;
  localparam logic [CfgIdxW-1:0] RegYOffset      = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 3'd6;
  localparam logic [CfgIdxW-1:0] RegNeededCount  = 3'd7;

  // Field widths
  localparam int unsigned LimitW  = 12;
  localparam int unsigned MarginW = 10;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned CountW  = 4;

  // Register reset values
  localparam logic [LimitW-1:0]  InitialLowRst   = 12'd230;
  localparam logic [LimitW-1:0]  InitialHighRst  = 12'd3860;
  localparam logic [MarginW-1:0] WindowMarginRst = 10'd100;
  localparam logic [OffsetW-1:0] XOffsetRst      = 12'd190;
  localparam logic [OffsetW-1:0] YOffsetRst      = 12'd300;
  localparam logic [CoordW-1:0]  ScreenWidthRst  = 10'd320;
  localparam logic [CoordW-1:0]  ScreenHeightRst = 10'd240;
  localparam logic [CountW-1:0]  NeededCountRst  = 4'd3;

endpackage

[hw/rtl/touch_sample_window_qualifier.sv]
// Touch sample window qualifier: a sample is held in the input register, and its result, if any,
// is loaded into the result register when the sample leaves the input register.
// Throughput one item per cycle: input register, one stage of window compare, re-centring
// and constant-reciprocal scaling, then a result register; input stalls only while both hold.
// Reset: registers take their reset values, windows open at the initial limits,
// accepted count is zero, both pipeline registers are empty. Depends on tswq_pkg.
module touch_sample_window_qualifier #(
  parameter int unsigned X_DIVISOR   = 11,
  parameter int unsigned Y_DIVISOR   = 14,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [tswq_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [tswq_pkg::CfgDataW-1:0]     cfg_data_i,
  // sample channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_BITS-1:0]            x_sample_i,
  input  logic [SAMPLE_BITS-1:0]            y_sample_i,
  input  logic                              pen_down_i,
  // coordinate channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [tswq_pkg::CoordW-1:0]       screen_x_o,
  output logic [tswq_pkg::CoordW-1:0]       screen_y_o
);

  // Derived widths
  localparam int unsigned WinW = SAMPLE_BITS + 1;
  localparam int unsigned AddW = ((WinW > tswq_pkg::MarginW) ? WinW : tswq_pkg::MarginW) + 1;
  localparam int unsigned DifW = (SAMPLE_BITS > tswq_pkg::OffsetW) ? SAMPLE_BITS
                                                                   : tswq_pkg::OffsetW;
  // Reciprocal scaling: floor(n / D) = (n * ceil(2^Sh / D)) >> Sh for n < 2^DifW, D <= 64
  localparam int unsigned RecSh = DifW + 6;
  localparam int unsigned RecW  = RecSh + 1;
  localparam int unsigned PrdW  = DifW + RecW;
  localparam longint unsigned XRecip = ((64'd1 << RecSh) + X_DIVISOR - 1) / X_DIVISOR;
  localparam longint unsigned YRecip = ((64'd1 << RecSh) + Y_DIVISOR - 1) / Y_DIVISOR;

  localparam logic [RecW-1:0] XRecipC = RecW'(XRecip);
  localparam logic [RecW-1:0] YRecipC = RecW'(YRecip);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic [tswq_pkg::LimitW-1:0]  init_low_q, init_high_q;
  logic [tswq_pkg::MarginW-1:0] margin_q;
  logic [tswq_pkg::OffsetW-1:0] x_offset_q, y_offset_q;
  logic [tswq_pkg::CoordW-1:0]  width_q, height_q;
  logic [tswq_pkg::CountW-1:0]  needed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_low_q  <= tswq_pkg::InitialLowRst;
      init_high_q <= tswq_pkg::InitialHighRst;
      margin_q    <= tswq_pkg::WindowMarginRst;
      x_offset_q  <= tswq_pkg::XOffsetRst;
      y_offset_q  <= tswq_pkg::YOffsetRst;
      width_q     <= tswq_pkg::ScreenWidthRst;
      height_q    <= tswq_pkg::ScreenHeightRst;
      needed_q    <= tswq_pkg::NeededCountRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tswq_pkg::RegInitialLow:   init_low_q  <= cfg_data_i[tswq_pkg::LimitW-1:0];
        tswq_pkg::RegInitialHigh:  init_high_q <= cfg_data_i[tswq_pkg::LimitW-1:0];
        tswq_pkg::RegWindowMargin: margin_q    <= cfg_data_i[tswq_pkg::MarginW-1:0];
        tswq_pkg::RegXOffset:      x_offset_q  <= cfg_data_i[tswq_pkg::OffsetW-1:0];
        tswq_pkg::RegYOffset:      y_offset_q  <= cfg_data_i[tswq_pkg::OffsetW-1:0];
        tswq_pkg::RegScreenWidth:  width_q     <= cfg_data_i[tswq_pkg::CoordW-1:0];
        tswq_pkg::RegScreenHeight: height_q    <= cfg_data_i[tswq_pkg::CoordW-1:0];
        tswq_pkg::RegNeededCount:  needed_q    <= cfg_data_i[tswq_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Handshake: input register and result register
  // ------------------------------------------------------------------
  logic                   s1_valid_q;
  logic [SAMPLE_BITS-1:0] s1_x_q, s1_y_q;
  logic                   s1_pen_q;
  logic                   s1_fire;
  logic                   out_valid_q;
  logic                   emit;

  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_x_q   <= x_sample_i;
      s1_y_q   <= y_sample_i;
      s1_pen_q <= pen_down_i;
    end
  end

  // ------------------------------------------------------------------
  // Window check and re-centring
  // ------------------------------------------------------------------
  logic [WinW-1:0]             x_low_q, x_high_q, y_low_q, y_high_q;
  logic [WinW-1:0]             x_low_d, x_high_d, y_low_d, y_high_d;
  logic [tswq_pkg::CountW-1:0] count_q, count_d, count_inc, need;
  logic [WinW-1:0]             x_w, y_w, init_low_w, init_high_w;
  logic [AddW-1:0]             x_a, y_a, m_a;
  logic                        in_window;

  assign x_w         = WinW'(s1_x_q);
  assign y_w         = WinW'(s1_y_q);
  assign init_low_w  = WinW'(init_low_q);
  assign init_high_w = WinW'(init_high_q);
  assign x_a         = AddW'(s1_x_q);
  assign y_a         = AddW'(s1_y_q);
  assign m_a         = AddW'(margin_q);

  assign in_window = (x_w > x_low_q) && (x_w < x_high_q) &&
                     (y_w > y_low_q) && (y_w < y_high_q);

  // zero needed count behaves as one
  assign need      = (needed_q == '0) ? tswq_pkg::CountW'(1) : needed_q;
  assign count_inc = count_q + tswq_pkg::CountW'(1);
  assign emit      = s1_pen_q && in_window && (count_inc >= need);

  always_comb begin
    x_low_d  = x_low_q;
    x_high_d = x_high_q;
    y_low_d  = y_low_q;
    y_high_d = y_high_q;
    count_d  = count_q;
    if (!s1_pen_q || emit) begin
      // session restart
      x_low_d  = init_low_w;
      y_low_d  = init_low_w;
      x_high_d = init_high_w;
      y_high_d = init_high_w;
      count_d  = '0;
    end else if (in_window) begin
      x_low_d  = (x_a > m_a) ? WinW'(x_a - m_a) : '0;
      y_low_d  = (y_a > m_a) ? WinW'(y_a - m_a) : '0;
      x_high_d = WinW'(x_a + m_a);
      y_high_d = WinW'(y_a + m_a);
      count_d  = count_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= WinW'(tswq_pkg::InitialLowRst);
      y_low_q  <= WinW'(tswq_pkg::InitialLowRst);
      x_high_q <= WinW'(tswq_pkg::InitialHighRst);
      y_high_q <= WinW'(tswq_pkg::InitialHighRst);
      count_q  <= '0;
    end else if (s1_fire) begin
      x_low_q  <= x_low_d;
      y_low_q  <= y_low_d;
      x_high_q <= x_high_d;
      y_high_q <= y_high_d;
      count_q  <= count_d;
    end
  end

  // ------------------------------------------------------------------
  // Scaling and mirroring
  // ------------------------------------------------------------------
  logic [DifW-1:0]             x_s, y_s, x_o, y_o, x_diff, y_diff;
  logic [PrdW-1:0]             x_prod, y_prod;
  logic [DifW-1:0]             x_scaled, y_scaled;
  logic [tswq_pkg::CoordW-1:0] scr_x_d, scr_y_d, scr_x_q, scr_y_q;

  assign x_s = DifW'(s1_x_q);
  assign y_s = DifW'(s1_y_q);
  assign x_o = DifW'(x_offset_q);
  assign y_o = DifW'(y_offset_q);

  // sample below offset scales to zero
  assign x_diff = (x_s >= x_o) ? (x_s - x_o) : '0;
  assign y_diff = (y_s >= y_o) ? (y_s - y_o) : '0;

  assign x_prod   = PrdW'(x_diff) * PrdW'(XRecipC);
  assign y_prod   = PrdW'(y_diff) * PrdW'(YRecipC);
  assign x_scaled = x_prod[RecSh +: DifW];
  assign y_scaled = y_prod[RecSh +: DifW];

  // mirror against screen size, clamp at zero
  assign scr_x_d = (DifW'(width_q) >= x_scaled)
                   ? (width_q - x_scaled[tswq_pkg::CoordW-1:0]) : '0;
  assign scr_y_d = (DifW'(height_q) >= y_scaled)
                   ? (height_q - y_scaled[tswq_pkg::CoordW-1:0]) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      scr_x_q <= scr_x_d;
      scr_y_q <= scr_y_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = scr_x_q;
  assign screen_y_o  = scr_y_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  a_pen_up_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && !s1_pen_q) |=> (count_q == '0) && !out_valid_q)
    else $error("pen release did not restart session");

  a_emit_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && emit) |=> (count_q == '0) && out_valid_q)
    else $error("emit did not restart session or raise result");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_count_only_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(count_q))
    else $error("accepted count moved without a transfer");

endmodule

[tb/sv/touch_coord_checker.sv]
`timescale 1ns / 1ps
// Checker for the touch sample window qualifier: mirrors the registers and the session
// state, predicts the coordinate each sample transfer causes and compares the results.
// Depends on tswq_pkg.
module touch_coord_checker #(
  parameter int XDivisor = 11,
  parameter int YDivisor = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tswq_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tswq_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [11:0]                   x_sample_i,
  input  logic [11:0]                   y_sample_i,
  input  logic                          pen_down_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [tswq_pkg::CoordW-1:0]   screen_x_i,
  input  logic [tswq_pkg::CoordW-1:0]   screen_y_i,
  output int unsigned                   error_count_o,
  output int unsigned                   coords_pending_o
);

  typedef struct packed {
    logic [tswq_pkg::CoordW-1:0] x;
    logic [tswq_pkg::CoordW-1:0] y;
  } screen_coord_t;

  // register mirror
  logic [tswq_pkg::LimitW-1:0]  initial_low, initial_high;
  logic [tswq_pkg::MarginW-1:0] window_margin;
  logic [tswq_pkg::OffsetW-1:0] x_offset, y_offset;
  logic [tswq_pkg::CoordW-1:0]  screen_width, screen_height;
  logic [tswq_pkg::CountW-1:0]  needed_count;

  // session state
  logic [12:0]                  x_lo, x_hi, y_lo, y_hi;
  logic [tswq_pkg::CountW-1:0]  accepted;

  screen_coord_t coord_q[$];

  task automatic report_mismatch(input string what);
    error_count_o = error_count_o + 1;
    $display("%0t ns: %s", $time, what);
  endtask

  task automatic restart_session();
    x_lo     = {1'b0, initial_low};
    y_lo     = {1'b0, initial_low};
    x_hi     = {1'b0, initial_high};
    y_hi     = {1'b0, initial_high};
    accepted = '0;
  endtask

  // offset, divide, then mirror against the screen size with a floor at zero
  function automatic logic [tswq_pkg::CoordW-1:0] mirror_axis(input int s, input int offset,
                                                              input int divisor, input int size);
    int scaled;
    scaled = (s >= offset) ? (s - offset) / divisor : 0;
    return (size >= scaled) ? tswq_pkg::CoordW'(size - scaled) : '0;
  endfunction

  task automatic write_register(input logic [tswq_pkg::CfgIdxW-1:0] idx,
                                input logic [tswq_pkg::CfgDataW-1:0] data);
    case (idx)
      tswq_pkg::RegInitialLow:   initial_low   = data;
      tswq_pkg::RegInitialHigh:  initial_high  = data;
      tswq_pkg::RegWindowMargin: window_margin = data[tswq_pkg::MarginW-1:0];
      tswq_pkg::RegXOffset:      x_offset      = data;
      tswq_pkg::RegYOffset:      y_offset      = data;
      tswq_pkg::RegScreenWidth:  screen_width  = data[tswq_pkg::CoordW-1:0];
      tswq_pkg::RegScreenHeight: screen_height = data[tswq_pkg::CoordW-1:0];
      tswq_pkg::RegNeededCount:  needed_count  = data[tswq_pkg::CountW-1:0];
      default: ;
    endcase
  endtask

  // window qualification for one sample transfer
  task automatic take_sample(input int xs, input int ys, input logic pen);
    int            m;
    int            need;
    screen_coord_t c;
    m = int'(window_margin);
    if (!pen) begin
      restart_session();
    end else if (xs > int'(x_lo) && xs < int'(x_hi) && ys > int'(y_lo) && ys < int'(y_hi)) begin
      // re-centre both windows, lower limits saturate at zero
      x_lo     = (xs > m) ? 13'(xs - m) : '0;
      y_lo     = (ys > m) ? 13'(ys - m) : '0;
      x_hi     = 13'(xs + m);
      y_hi     = 13'(ys + m);
      accepted = accepted + 1'b1;
      need     = (needed_count == 0) ? 1 : int'(needed_count);
      if (int'(accepted) >= need) begin
        c.x = mirror_axis(xs, int'(x_offset), XDivisor, int'(screen_width));
        c.y = mirror_axis(ys, int'(y_offset), YDivisor, int'(screen_height));
        coord_q.push_back(c);
        restart_session();
      end
    end
  endtask

  task automatic check_coord();
    screen_coord_t exp_c;
    if (coord_q.size() == 0) begin
      report_mismatch($sformatf("coordinate (%0d,%0d) transferred with none expected",
                                screen_x_i, screen_y_i));
    end else begin
      exp_c = coord_q.pop_front();
      if (screen_x_i !== exp_c.x)
        report_mismatch($sformatf("screen_x %0d, expected %0d", screen_x_i, exp_c.x));
      if (screen_y_i !== exp_c.y)
        report_mismatch($sformatf("screen_y %0d, expected %0d", screen_y_i, exp_c.y));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_low      = tswq_pkg::InitialLowRst;
      initial_high     = tswq_pkg::InitialHighRst;
      window_margin    = tswq_pkg::WindowMarginRst;
      x_offset         = tswq_pkg::XOffsetRst;
      y_offset         = tswq_pkg::YOffsetRst;
      screen_width     = tswq_pkg::ScreenWidthRst;
      screen_height    = tswq_pkg::ScreenHeightRst;
      needed_count     = tswq_pkg::NeededCountRst;
      restart_session();
      coord_q.delete();
      error_count_o    = 0;
      coords_pending_o <= 0;
    end else begin
      if (cfg_we_i) write_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) take_sample(int'(x_sample_i), int'(y_sample_i), pen_down_i);
      if (out_valid_i && out_ready_i) check_coord();
      coords_pending_o <= coord_q.size();
    end
  end

endmodule

[tb/sv/touch_sample_window_qualifier_tb.sv]
`timescale 1ns / 1ps
// Top of the touch sample window qualifier testbench: clock, reset, register phases,
// sample stimulus and coordinate receiver pacing, and the verdict.
// Depends on tswq_pkg, touch_sample_window_qualifier and touch_coord_checker.
module touch_sample_window_qualifier_tb;

  localparam int SampleW        = 12;
  localparam int XDivisor       = 11;
  localparam int YDivisor       = 14;
  localparam int MaxGap         = 12;
  localparam int SinkHoldCycles = 400;
  localparam int NumPhases      = 10;

  typedef struct {
    logic [tswq_pkg::LimitW-1:0]  init_lo;
    logic [tswq_pkg::LimitW-1:0]  init_hi;
    logic [tswq_pkg::MarginW-1:0] margin;
    logic [tswq_pkg::OffsetW-1:0] x_off;
    logic [tswq_pkg::OffsetW-1:0] y_off;
    logic [tswq_pkg::CoordW-1:0]  width;
    logic [tswq_pkg::CoordW-1:0]  height;
    logic [tswq_pkg::CountW-1:0]  need;
  } panel_cfg_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          cfg_we    = 1'b0;
  logic [tswq_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [tswq_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic [SampleW-1:0]            x_sample  = '0;
  logic [SampleW-1:0]            y_sample  = '0;
  logic                          pen_down  = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [tswq_pkg::CoordW-1:0]   screen_x, screen_y;
  int unsigned                   mismatches;
  int unsigned                   coords_pending;

  bit         gaps_on   = 1'b1;
  int         sink_hold = 0;
  int         touch_x, touch_y;
  panel_cfg_t cur_cfg   = '{tswq_pkg::InitialLowRst, tswq_pkg::InitialHighRst,
                            tswq_pkg::WindowMarginRst, tswq_pkg::XOffsetRst,
                            tswq_pkg::YOffsetRst, tswq_pkg::ScreenWidthRst,
                            tswq_pkg::ScreenHeightRst, tswq_pkg::NeededCountRst};

  touch_sample_window_qualifier #(
    .X_DIVISOR  (XDivisor),
    .Y_DIVISOR  (YDivisor),
    .SAMPLE_BITS(SampleW)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .x_sample_i (x_sample),
    .y_sample_i (y_sample),
    .pen_down_i (pen_down),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .screen_x_o (screen_x),
    .screen_y_o (screen_y)
  );

  touch_coord_checker #(
    .XDivisor(XDivisor),
    .YDivisor(YDivisor)
  ) coord_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .x_sample_i      (x_sample),
    .y_sample_i      (y_sample),
    .pen_down_i      (pen_down),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .screen_x_i      (screen_x),
    .screen_y_i      (screen_y),
    .error_count_o   (mismatches),
    .coords_pending_o(coords_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("touch_sample_window_qualifier_tb: done, errors");
    $finish;
  end

  // one sample transfer; valid stays high afterwards unless the next item idles first
  task automatic send_sample(input int xs, input int ys, input logic pen);
    int gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_sample <= xs[SampleW-1:0];
    y_sample <= ys[SampleW-1:0];
    pen_down <= pen;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering, let every expected coordinate arrive, then let the pipeline empty
  task automatic drain_coords(input int limit);
    int waited;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (coords_pending != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tswq_pkg::CfgIdxW-1:0] idx,
                           input logic [tswq_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_panel_cfg(input panel_cfg_t c);
    write_reg(tswq_pkg::RegInitialLow,   c.init_lo);
    write_reg(tswq_pkg::RegInitialHigh,  c.init_hi);
    write_reg(tswq_pkg::RegWindowMargin, tswq_pkg::CfgDataW'(c.margin));
    write_reg(tswq_pkg::RegXOffset,      c.x_off);
    write_reg(tswq_pkg::RegYOffset,      c.y_off);
    write_reg(tswq_pkg::RegScreenWidth,  tswq_pkg::CfgDataW'(c.width));
    write_reg(tswq_pkg::RegScreenHeight, tswq_pkg::CfgDataW'(c.height));
    write_reg(tswq_pkg::RegNeededCount,  tswq_pkg::CfgDataW'(c.need));
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic panel_cfg_t random_panel_cfg();
    panel_cfg_t c;
    c.init_lo = tswq_pkg::LimitW'($urandom_range(0, 1500));
    c.init_hi = tswq_pkg::LimitW'($urandom_range(2500, 4095));
    c.margin  = tswq_pkg::MarginW'($urandom_range(2, 1023));
    c.x_off   = tswq_pkg::OffsetW'($urandom_range(0, 1) ? $urandom_range(0, 600)
                                                        : $urandom_range(0, 4095));
    c.y_off   = tswq_pkg::OffsetW'($urandom_range(0, 1) ? $urandom_range(0, 600)
                                                        : $urandom_range(0, 4095));
    c.width   = tswq_pkg::CoordW'($urandom_range(0, 1023));
    c.height  = tswq_pkg::CoordW'($urandom_range(0, 1023));
    c.need    = tswq_pkg::CountW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(1, 4));
    return c;
  endfunction

  // extremes first, then random settings
  function automatic panel_cfg_t phase_cfg(input int p);
    case (p)
      1:       return '{0, 4095, 1023, 0, 0, 1023, 1023, 1};
      2:       return '{4095, 0, 0, 4095, 4095, 0, 0, 15};   // empty windows
      3:       return '{100, 4000, 1, 4095, 4095, 0, 0, 0};  // count zero acts as one
      default: return random_panel_cfg();
    endcase
  endfunction

  function automatic int phase_items(input int p);
    case (p)
      0:       return 160;
      1:       return 200;
      2:       return 60;
      3:       return 120;
      default: return 150;
    endcase
  endfunction

  // new touch point inside the initial window where that window is open
  task automatic start_touch();
    int lo, hi;
    lo = int'(cur_cfg.init_lo);
    hi = int'(cur_cfg.init_hi);
    if (hi - lo >= 2) begin
      touch_x = $urandom_range(lo + 1, hi - 1);
      touch_y = $urandom_range(lo + 1, hi - 1);
    end else begin
      touch_x = $urandom_range(0, 4095);
      touch_y = $urandom_range(0, 4095);
    end
  endtask

  function automatic int clamp_sample(input int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // mostly steady touches with jitter under the margin; some releases and noise
  task automatic send_touch_item();
    int pick, jit, xs, ys;
    pick = $urandom_range(0, 99);
    jit  = (cur_cfg.margin > 1) ? (int'(cur_cfg.margin) - 1) / 2 : 0;
    if (pick < 8) begin
      send_sample($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0);
      start_touch();
    end else if (pick < 20) begin
      send_sample($urandom_range(0, 4095), $urandom_range(0, 4095), 1'($urandom_range(0, 1)));
    end else begin
      xs = clamp_sample(touch_x + int'($urandom_range(0, 2 * jit)) - jit);
      ys = clamp_sample(touch_y + int'($urandom_range(0, 2 * jit)) - jit);
      send_sample(xs, ys, 1'b1);
    end
  endtask

  // directed samples at the reset settings
  task automatic directed_items();
    send_sample(0, 0, 1'b0);          // releases at both field extremes
    send_sample(4095, 4095, 1'b0);
    send_sample(0, 0, 1'b1);          // outside the initial window
    send_sample(4095, 4095, 1'b1);
    send_sample(230, 231, 1'b1);      // on the limits: strict compare rejects
    send_sample(3860, 1000, 1'b1);
    send_sample(231, 231, 1'b1);      // three accepts, emit
    send_sample(250, 250, 1'b1);
    send_sample(300, 300, 1'b1);
    send_sample(1000, 1000, 1'b1);    // rejected sample mid-session
    send_sample(2000, 2000, 1'b1);
    send_sample(1099, 1099, 1'b1);
    send_sample(1000, 1000, 1'b1);
    send_sample(1500, 1500, 1'b1);    // release mid-session clears the count
    send_sample(0, 0, 1'b0);
    send_sample(1500, 1500, 1'b1);
    send_sample(1590, 1590, 1'b1);
    send_sample(1599, 1599, 1'b1);
    send_sample(3750, 3750, 1'b1);    // scaled past the screen size: floor at zero
    send_sample(3760, 3760, 1'b1);
    send_sample(3770, 3770, 1'b1);
    send_sample(240, 240, 1'b1);      // Y below its offset
    send_sample(245, 245, 1'b1);
    send_sample(250, 250, 1'b1);
  endtask

  // coordinate receiver
  initial begin : coord_sink
    int stall;
    @(posedge rst_n);
    forever begin
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end else begin
        stall = gaps_on ? $urandom_range(0, MaxGap) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // stimulus and verdict
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain_coords(5000);
        load_panel_cfg(phase_cfg(p));
      end
      gaps_on = (p % 3 != 1);
      // long receiver stall while samples keep coming
      if (p == 1) sink_hold = SinkHoldCycles;
      start_touch();
      repeat (phase_items(p)) send_touch_item();
    end
    drain_coords(5000);
    if (coords_pending != 0)
      $display("%0d expected coordinates never arrived", coords_pending);
    if (mismatches == 0 && coords_pending == 0) begin
      $display("touch_sample_window_qualifier_tb: done, clean");
    end else begin
      $display("touch_sample_window_qualifier_tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/tswq_pkg.sv
hw/rtl/touch_sample_window_qualifier.sv
tb/sv/touch_coord_checker.sv
tb/sv/touch_sample_window_qualifier_tb.sv
